@@ sv/ckp_pkg.sv @@
// Shared types, constants and helper functions for the chroma key pixel pipeline.
// No dependencies; every other file imports this package.
package ckp_pkg;

    localparam int CHAN_W = 8;
    localparam int SQ_W = 2 * CHAN_W;
    localparam int DIST_W = 18;
    localparam int THR_W = 20;
    localparam int NUM_W = CHAN_W + DIST_W;
    localparam int QUO_W = CHAN_W;
    localparam int REM_W = THR_W + QUO_W;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES = QUO_W / DIV_BITS_PER_STAGE;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = THR_W;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_RED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_GREEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_BLUE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HARD_THRESHOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_THRESHOLD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPILL_SUPPRESS = 3'd6;

    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;

    typedef enum logic [1:0] {
        MATTE_PASS,
        MATTE_CLEAR,
        MATTE_SOFT,
        MATTE_KEEP
    } band_t;

    typedef struct packed {
        logic              key_enable;
        logic [CHAN_W-1:0] key_red;
        logic [CHAN_W-1:0] key_green;
        logic [CHAN_W-1:0] key_blue;
        logic [THR_W-1:0]  hard_threshold;
        logic [THR_W-1:0]  soft_threshold;
        logic              spill_suppress;
    } cfg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] a;
        band_t             band;
    } pix_t;

    // Exact floor(p / 255) for any product of two 8-bit values.
    function automatic logic [CHAN_W-1:0] div255(input logic [SQ_W-1:0] p);
        logic [SQ_W:0] s;
        s = {1'b0, p} + (SQ_W + 1)'(1) + (SQ_W + 1)'(p[SQ_W-1:CHAN_W]);
        return s[SQ_W-1:CHAN_W];
    endfunction

    function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] x,
                                                  input logic [CHAN_W-1:0] y);
        return (x > y) ? (x - y) : (y - x);
    endfunction

    function automatic logic [CHAN_W-1:0] max8(input logic [CHAN_W-1:0] x,
                                               input logic [CHAN_W-1:0] y);
        return (x > y) ? x : y;
    endfunction

endpackage

@@ sv/chroma_key_pixel.sv @@
// Chroma keyer with soft matte and spill suppression for an ARGB pixel stream.
// Instantiates ckp_cfg_regs, ckp_matte, ckp_div and ckp_scale; depends on ckp_pkg.
//
// Pixels enter on in_valid with red, green, blue and alpha; a request is taken
// at a rising edge where in_valid is high and in_stall is low. Results leave on
// out_valid with out_red, out_green, out_blue and out_alpha, and are taken
// when out_valid is high and out_stall is low.
// Registers are written through cfg_valid, cfg_index and cfg_data; cfg_ready
// is always high. Write them only while no pixel is in flight.
// The datapath is ten register stages: one pixel per clock is accepted while
// the output is not stalled. Four matte stages, four divider stages with two
// quotient bits each and two scaling stages set that depth.
// While the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall is raised; nothing is dropped or repeated.
// Reset empties the pipeline and loads the key color with pure green,
// thresholds at zero and keying and spill suppression disabled.
module chroma_key_pixel
    import ckp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CHAN_W-1:0]     red,
    input  logic [CHAN_W-1:0]     green,
    input  logic [CHAN_W-1:0]     blue,
    input  logic [CHAN_W-1:0]     alpha,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CHAN_W-1:0]     out_red,
    output logic [CHAN_W-1:0]     out_green,
    output logic [CHAN_W-1:0]     out_blue,
    output logic [CHAN_W-1:0]     out_alpha,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t             cfg;
    logic             adv;
    logic             m_valid;
    pix_t             m_pix;
    logic [NUM_W-1:0] m_num;
    logic [THR_W-1:0] m_den;
    logic             q_valid;
    pix_t             q_pix;
    logic [QUO_W-1:0] q_quo;

    assign adv = !out_valid || !out_stall;
    assign in_stall = !adv;

    ckp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ckp_matte u_matte (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .cfg      (cfg),
        .in_valid (in_valid),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .alpha    (alpha),
        .valid    (m_valid),
        .pix      (m_pix),
        .num      (m_num),
        .den      (m_den)
    );

    ckp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (m_valid),
        .in_pix   (m_pix),
        .num      (m_num),
        .den      (m_den),
        .valid    (q_valid),
        .pix      (q_pix),
        .quo      (q_quo)
    );

    ckp_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (q_valid),
        .pix       (q_pix),
        .quo       (q_quo),
        .valid     (out_valid),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha)
    );

endmodule

@@ sv/ckp_cfg_regs.sv @@
// Configuration register file for the chroma key pixel pipeline.
// Depends on ckp_pkg for the register indexes and the cfg_t bundle.
module ckp_cfg_regs
    import ckp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_KEY_ENABLE:     cfg_next.key_enable = cfg_data[0];
                REG_KEY_RED:        cfg_next.key_red = cfg_data[CHAN_W-1:0];
                REG_KEY_GREEN:      cfg_next.key_green = cfg_data[CHAN_W-1:0];
                REG_KEY_BLUE:       cfg_next.key_blue = cfg_data[CHAN_W-1:0];
                REG_HARD_THRESHOLD: cfg_next.hard_threshold = cfg_data[THR_W-1:0];
                REG_SOFT_THRESHOLD: cfg_next.soft_threshold = cfg_data[THR_W-1:0];
                REG_SPILL_SUPPRESS: cfg_next.spill_suppress = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_enable <= 1'b0;
            cfg_reg.key_red <= '0;
            cfg_reg.key_green <= FULL_SCALE;
            cfg_reg.key_blue <= '0;
            cfg_reg.hard_threshold <= '0;
            cfg_reg.soft_threshold <= '0;
            cfg_reg.spill_suppress <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ sv/ckp_matte.sv @@
// Distance, band classification, spill clamp and alpha numerator stages.
// Four register stages; depends on ckp_pkg.
module ckp_matte
    import ckp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  cfg_t              cfg,
    input  logic              in_valid,
    input  logic [CHAN_W-1:0] red,
    input  logic [CHAN_W-1:0] green,
    input  logic [CHAN_W-1:0] blue,
    input  logic [CHAN_W-1:0] alpha,
    output logic              valid,
    output pix_t              pix,
    output logic [NUM_W-1:0]  num,
    output logic [THR_W-1:0]  den
);

    logic              a_valid_reg;
    pix_t              a_pix_reg;
    logic [CHAN_W-1:0] a_gcl_reg;
    logic [CHAN_W-1:0] a_bcl_reg;
    logic [CHAN_W-1:0] a_dr_reg;
    logic [CHAN_W-1:0] a_dg_reg;
    logic [CHAN_W-1:0] a_db_reg;

    logic              b_valid_reg;
    pix_t              b_pix_reg;
    logic [CHAN_W-1:0] b_gcl_reg;
    logic [CHAN_W-1:0] b_bcl_reg;
    logic [SQ_W-1:0]   b_sqr_reg;
    logic [SQ_W-1:0]   b_sqg_reg;
    logic [SQ_W-1:0]   b_sqb_reg;

    logic              c_valid_reg;
    pix_t              c_pix_reg;
    pix_t              c_pix_next;
    logic [DIST_W-1:0] c_dh_reg;
    logic [DIST_W-1:0] c_dh_next;
    logic [THR_W-1:0]  c_den_reg;

    logic              d_valid_reg;
    pix_t              d_pix_reg;
    logic [NUM_W-1:0]  d_num_reg;
    logic [THR_W-1:0]  d_den_reg;

    logic [DIST_W-1:0] dist_sum;
    logic              below_hard;
    logic              in_band;
    logic              green_key;
    logic              blue_key;

    always_comb
    begin
        dist_sum = DIST_W'(b_sqr_reg) + DIST_W'(b_sqg_reg) + DIST_W'(b_sqb_reg);
        below_hard = THR_W'(dist_sum) < cfg.hard_threshold;
        in_band = !below_hard && (THR_W'(dist_sum) < cfg.soft_threshold)
                  && (cfg.soft_threshold > cfg.hard_threshold);
        green_key = (cfg.key_green > cfg.key_red) && (cfg.key_green > cfg.key_blue);
        blue_key = (cfg.key_blue > cfg.key_red) && (cfg.key_blue > cfg.key_green);
        c_dh_next = dist_sum - cfg.hard_threshold[DIST_W-1:0];
        c_pix_next = b_pix_reg;
        if (!cfg.key_enable)
        begin
            c_pix_next.band = MATTE_PASS;
        end
        else if (below_hard)
        begin
            c_pix_next.band = MATTE_CLEAR;
        end
        else if (in_band)
        begin
            c_pix_next.band = MATTE_SOFT;
            if (cfg.spill_suppress && green_key)
            begin
                c_pix_next.g = b_gcl_reg;
            end
            else if (cfg.spill_suppress && blue_key)
            begin
                c_pix_next.b = b_bcl_reg;
            end
        end
        else
        begin
            c_pix_next.band = MATTE_KEEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_pix_reg.r <= red;
            a_pix_reg.g <= green;
            a_pix_reg.b <= blue;
            a_pix_reg.a <= alpha;
            a_pix_reg.band <= MATTE_KEEP;
            a_gcl_reg <= (green > max8(red, blue)) ? max8(red, blue) : green;
            a_bcl_reg <= (blue > max8(red, green)) ? max8(red, green) : blue;
            a_dr_reg <= absdiff(red, cfg.key_red);
            a_dg_reg <= absdiff(green, cfg.key_green);
            a_db_reg <= absdiff(blue, cfg.key_blue);

            b_pix_reg <= a_pix_reg;
            b_gcl_reg <= a_gcl_reg;
            b_bcl_reg <= a_bcl_reg;
            b_sqr_reg <= SQ_W'(a_dr_reg) * SQ_W'(a_dr_reg);
            b_sqg_reg <= SQ_W'(a_dg_reg) * SQ_W'(a_dg_reg);
            b_sqb_reg <= SQ_W'(a_db_reg) * SQ_W'(a_db_reg);

            c_pix_reg <= c_pix_next;
            c_dh_reg <= c_dh_next;
            c_den_reg <= cfg.soft_threshold - cfg.hard_threshold;

            d_pix_reg <= c_pix_reg;
            d_num_reg <= NUM_W'(c_pix_reg.a) * NUM_W'(c_dh_reg);
            d_den_reg <= c_den_reg;
        end
    end

    assign valid = d_valid_reg;
    assign pix = d_pix_reg;
    assign num = d_num_reg;
    assign den = d_den_reg;

endmodule

@@ sv/ckp_div.sv @@
// Pipelined restoring divider for the soft-band alpha, two quotient bits per stage.
// The pixel record travels alongside; depends on ckp_pkg.
module ckp_div
    import ckp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  pix_t             in_pix,
    input  logic [NUM_W-1:0] num,
    input  logic [THR_W-1:0] den,
    output logic             valid,
    output pix_t             pix,
    output logic [QUO_W-1:0] quo
);

    logic             valid_reg [DIV_STAGES];
    pix_t             pix_reg   [DIV_STAGES];
    logic [REM_W-1:0] rem_reg   [DIV_STAGES];
    logic [THR_W-1:0] den_reg   [DIV_STAGES];
    logic [QUO_W-1:0] quo_reg   [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic             v_src;
        pix_t             p_src;
        logic [REM_W-1:0] r_src;
        logic [THR_W-1:0] d_src;
        logic [QUO_W-1:0] q_src;
        logic [REM_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        if (s == 0)
        begin : g_first
            assign v_src = in_valid;
            assign p_src = in_pix;
            assign r_src = REM_W'(num);
            assign d_src = den;
            assign q_src = '0;
        end
        else
        begin : g_rest
            assign v_src = valid_reg[s-1];
            assign p_src = pix_reg[s-1];
            assign r_src = rem_reg[s-1];
            assign d_src = den_reg[s-1];
            assign q_src = quo_reg[s-1];
        end

        always_comb
        begin
            logic [REM_W-1:0] trial;
            rem_next = r_src;
            quo_next = q_src;
            for (int j = 0; j < DIV_BITS_PER_STAGE; j++)
            begin
                trial = REM_W'(d_src) << (QUO_W - 1 - (s * DIV_BITS_PER_STAGE + j));
                if (rem_next >= trial)
                begin
                    rem_next = rem_next - trial;
                    quo_next[QUO_W - 1 - (s * DIV_BITS_PER_STAGE + j)] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[s] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pix_reg[s] <= p_src;
                rem_reg[s] <= rem_next;
                den_reg[s] <= d_src;
                quo_reg[s] <= quo_next;
            end
        end
    end

    assign valid = valid_reg[DIV_STAGES-1];
    assign pix = pix_reg[DIV_STAGES-1];
    assign quo = quo_reg[DIV_STAGES-1];

endmodule

@@ sv/ckp_scale.sv @@
// Alpha selection, premultiply by the new alpha (by 255 for a passed pixel) and exact divide by 255.
// Holds the output register stage; depends on ckp_pkg.
module ckp_scale
    import ckp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  pix_t              pix,
    input  logic [QUO_W-1:0]  quo,
    output logic              valid,
    output logic [CHAN_W-1:0] out_red,
    output logic [CHAN_W-1:0] out_green,
    output logic [CHAN_W-1:0] out_blue,
    output logic [CHAN_W-1:0] out_alpha
);

    logic              f_valid_reg;
    logic [SQ_W-1:0]   f_pr_reg;
    logic [SQ_W-1:0]   f_pg_reg;
    logic [SQ_W-1:0]   f_pb_reg;
    logic [CHAN_W-1:0] f_alpha_reg;

    logic              o_valid_reg;
    logic [CHAN_W-1:0] o_red_reg;
    logic [CHAN_W-1:0] o_green_reg;
    logic [CHAN_W-1:0] o_blue_reg;
    logic [CHAN_W-1:0] o_alpha_reg;

    logic [CHAN_W-1:0] new_alpha;
    logic [CHAN_W-1:0] factor;

    // A passed pixel is scaled by 255/255 so that it comes out unchanged.
    always_comb
    begin
        case (pix.band)
            MATTE_PASS:
            begin
                new_alpha = pix.a;
                factor = FULL_SCALE;
            end
            MATTE_CLEAR:
            begin
                new_alpha = '0;
                factor = '0;
            end
            MATTE_SOFT:
            begin
                new_alpha = quo;
                factor = quo;
            end
            default:
            begin
                new_alpha = pix.a;
                factor = pix.a;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_valid_reg <= in_valid;
            o_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_pr_reg <= SQ_W'(pix.r) * SQ_W'(factor);
            f_pg_reg <= SQ_W'(pix.g) * SQ_W'(factor);
            f_pb_reg <= SQ_W'(pix.b) * SQ_W'(factor);
            f_alpha_reg <= new_alpha;

            o_red_reg <= div255(f_pr_reg);
            o_green_reg <= div255(f_pg_reg);
            o_blue_reg <= div255(f_pb_reg);
            o_alpha_reg <= f_alpha_reg;
        end
    end

    assign valid = o_valid_reg;
    assign out_red = o_red_reg;
    assign out_green = o_green_reg;
    assign out_blue = o_blue_reg;
    assign out_alpha = o_alpha_reg;

endmodule
